@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the contact manifold block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define CBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define CBM_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CBM_ASSERT(label, clk, rst_n, prop, msg)
`define CBM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/cbm_pkg.sv @@
// ----------------------------------------------------------------------------
// Contact manifold package
// Shared types and constants for the circle and box contact manifold block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

    // Unit length of a normal component in Q2.14.
    localparam logic signed [15:0] UNIT_NORMAL = 16'sd16384;

    // Reset value of the hit threshold, about 0.15 in Q16.16.
    localparam logic [31:0] SKIN_RESET = 32'd9830;

    // One root bit per square root stage, one quotient bit per divide stage.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;

    // Shape pair codes.
    typedef enum logic [1:0] {
        KIND_CC = 2'd0,
        KIND_CB = 2'd1,
        KIND_BC = 2'd2,
        KIND_BB = 2'd3
    } kind_t;

    // A finished contact, penetration one bit wider before saturation.
    typedef struct packed {
        logic               ov;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [32:0]        pen;
    } contact_t;

    // Word passed from the front to the back through the queue.
    typedef struct packed {
        logic               use_dist;
        logic               flip;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic [31:0]        rad;
        contact_t           direct;
    } work_t;

    // Word carried down the distance pipeline of the back.
    typedef struct packed {
        logic        use_dist;
        logic        flip;
        logic        fail;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] rad;
        logic [31:0] ax;
        logic [31:0] ay;
        contact_t    direct;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/cbm_front.sv @@
// ----------------------------------------------------------------------------
// Contact manifold front
// Three-stage classifier: offsets, box clamping, and the cases that need no
// distance (box-box and a circle centre inside a box) are settled here.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               in_valid,
    input  logic [1:0]         kind,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic [30:0]        first_size_a,
    input  logic [30:0]        first_size_b,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic [30:0]        second_size_a,
    input  logic [30:0]        second_size_b,
    output logic               word_valid,
    output cbm_pkg::work_t     word
);
    import cbm_pkg::*;

    // ------------------------------------------------------------------
    // Stage 1: centre offsets, box selection and summed sizes.
    // ------------------------------------------------------------------
    kind_t              kind_in;
    logic signed [32:0] fx_ext;
    logic signed [32:0] fy_ext;
    logic signed [32:0] sx_ext;
    logic signed [32:0] sy_ext;

    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic signed [32:0] s1_px_reg;
    logic signed [32:0] s1_py_reg;
    logic [30:0]        s1_w_reg;
    logic [30:0]        s1_h_reg;
    logic [31:0]        s1_rad_reg;
    logic [30:0]        s1_hx_reg;
    logic [30:0]        s1_hy_reg;

    assign kind_in = kind_t'(kind);
    assign fx_ext  = {first_x[31], first_x};
    assign fy_ext  = {first_y[31], first_y};
    assign sx_ext  = {second_x[31], second_x};
    assign sy_ext  = {second_y[31], second_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg <= kind_in;
            // The offset is taken from the box to the circle in box cases.
            if (kind_in == KIND_CB)
            begin
                s1_px_reg  <= fx_ext - sx_ext;
                s1_py_reg  <= fy_ext - sy_ext;
                s1_w_reg   <= second_size_a;
                s1_h_reg   <= second_size_b;
                s1_rad_reg <= {1'b0, first_size_a};
            end
            else
            begin
                s1_px_reg  <= sx_ext - fx_ext;
                s1_py_reg  <= sy_ext - fy_ext;
                s1_w_reg   <= first_size_a;
                s1_h_reg   <= first_size_b;
                if (kind_in == KIND_CC)
                begin
                    s1_rad_reg <= {1'b0, first_size_a} + {1'b0, second_size_a};
                end
                else
                begin
                    s1_rad_reg <= {1'b0, second_size_a};
                end
            end
            s1_hx_reg <= {1'b0, first_size_a[30:1]} + {1'b0, second_size_a[30:1]};
            s1_hy_reg <= {1'b0, first_size_b[30:1]} + {1'b0, second_size_b[30:1]};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: clamp to the box, distance offsets, overlaps.
    // ------------------------------------------------------------------
    logic signed [32:0] ex_s;
    logic signed [32:0] ey_s;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic [32:0]        mag_x;
    logic [32:0]        mag_y;
    logic               in_x;
    logic               in_y;
    logic [33:0]        pin_x;
    logic [33:0]        pin_y;

    logic               s2_valid_reg;
    kind_t              s2_kind_reg;
    logic               s2_posx_reg;
    logic               s2_negx_reg;
    logic               s2_posy_reg;
    logic               s2_negy_reg;
    logic               s2_inside_reg;
    logic               s2_gtx_reg;
    logic signed [32:0] s2_vx_reg;
    logic signed [32:0] s2_vy_reg;
    logic [31:0]        s2_rad_reg;
    logic [32:0]        s2_pinx_reg;
    logic [32:0]        s2_piny_reg;
    logic signed [33:0] s2_ox_reg;
    logic signed [33:0] s2_oy_reg;

    assign ex_s  = signed'({3'b000, s1_w_reg[30:1]});
    assign ey_s  = signed'({3'b000, s1_h_reg[30:1]});
    assign mag_x = s1_px_reg[32] ? unsigned'(-s1_px_reg) : unsigned'(s1_px_reg);
    assign mag_y = s1_py_reg[32] ? unsigned'(-s1_py_reg) : unsigned'(s1_py_reg);

    // Nearest point of the box to the circle centre.
    always_comb
    begin
        in_x = 1'b1;
        in_y = 1'b1;
        cx   = s1_px_reg;
        cy   = s1_py_reg;
        if (s1_px_reg < -ex_s)
        begin
            cx   = -ex_s;
            in_x = 1'b0;
        end
        else if (s1_px_reg > ex_s)
        begin
            cx   = ex_s;
            in_x = 1'b0;
        end
        if (s1_py_reg < -ey_s)
        begin
            cy   = -ey_s;
            in_y = 1'b0;
        end
        else if (s1_py_reg > ey_s)
        begin
            cy   = ey_s;
            in_y = 1'b0;
        end
    end

    // Depth for a centre inside the box: radius plus the gap to the edge.
    assign pin_x = {2'b00, s1_rad_reg} + {4'b0000, s1_w_reg[30:1]} - {1'b0, mag_x};
    assign pin_y = {2'b00, s1_rad_reg} + {4'b0000, s1_h_reg[30:1]} - {1'b0, mag_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_kind_reg   <= s1_kind_reg;
            s2_posx_reg   <= s1_px_reg > 33'sd0;
            s2_negx_reg   <= s1_px_reg[32];
            s2_posy_reg   <= s1_py_reg > 33'sd0;
            s2_negy_reg   <= s1_py_reg[32];
            s2_inside_reg <= in_x && in_y;
            s2_gtx_reg    <= mag_x > mag_y;
            s2_rad_reg    <= s1_rad_reg;
            s2_pinx_reg   <= pin_x[32:0];
            s2_piny_reg   <= pin_y[32:0];
            s2_ox_reg     <= signed'({3'b000, s1_hx_reg}) - signed'({1'b0, mag_x});
            s2_oy_reg     <= signed'({3'b000, s1_hy_reg}) - signed'({1'b0, mag_y});
            if (s1_kind_reg == KIND_CC)
            begin
                s2_vx_reg <= s1_px_reg;
                s2_vy_reg <= s1_py_reg;
            end
            else
            begin
                s2_vx_reg <= s1_px_reg - cx;
                s2_vy_reg <= s1_py_reg - cy;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: classify and settle the direct cases.
    // ------------------------------------------------------------------
    work_t              w3;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;

    logic               s3_valid_reg;
    work_t              s3_word_reg;

    always_comb
    begin
        w3      = '0;
        w3.vx   = s2_vx_reg;
        w3.vy   = s2_vy_reg;
        w3.rad  = s2_rad_reg;
        axis_x  = s2_posx_reg ? UNIT_NORMAL : -UNIT_NORMAL;
        axis_y  = s2_posy_reg ? UNIT_NORMAL : -UNIT_NORMAL;
        unique case (s2_kind_reg) inside
            KIND_CC:
            begin
                w3.use_dist = 1'b1;
            end
            KIND_CB, KIND_BC:
            begin
                if (s2_inside_reg)
                begin
                    w3.direct.ov = 1'b1;
                    if (s2_gtx_reg)
                    begin
                        w3.direct.nx  = (s2_kind_reg == KIND_CB) ? -axis_x : axis_x;
                        w3.direct.pen = s2_pinx_reg;
                    end
                    else
                    begin
                        w3.direct.ny  = (s2_kind_reg == KIND_CB) ? -axis_y : axis_y;
                        w3.direct.pen = s2_piny_reg;
                    end
                end
                else
                begin
                    w3.use_dist = 1'b1;
                    w3.flip     = (s2_kind_reg == KIND_CB);
                end
            end
            KIND_BB:
            begin
                if (s2_ox_reg > 34'sd0 && s2_oy_reg > 34'sd0)
                begin
                    w3.direct.ov = 1'b1;
                    if (s2_ox_reg > s2_oy_reg)
                    begin
                        w3.direct.nx  = s2_negx_reg ? -UNIT_NORMAL : UNIT_NORMAL;
                        w3.direct.pen = unsigned'(s2_ox_reg[32:0]);
                    end
                    else
                    begin
                        w3.direct.ny  = s2_negy_reg ? -UNIT_NORMAL : UNIT_NORMAL;
                        w3.direct.pen = unsigned'(s2_oy_reg[32:0]);
                    end
                end
            end
            default:
            begin
                w3.use_dist = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_word_reg <= w3;
        end
    end

    assign word_valid = s3_valid_reg;
    assign word       = s3_word_reg;

endmodule

`default_nettype wire

@@ hdl/cbm_queue.sv @@
// ----------------------------------------------------------------------------
// Contact manifold queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbm_pkg::work_t wdata,
    input  logic           pop,
    output cbm_pkg::work_t rdata,
    output logic           full,
    output logic           empty
);
    import cbm_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LAST = PtrW'(DEPTH - 1);

    work_t           store [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == CntW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = store[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbm_back.sv @@
// ----------------------------------------------------------------------------
// Contact manifold back
// Distance pipeline: magnitudes, squares, a one-bit-per-stage square root,
// a one-bit-per-stage normal divider, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cbm_pkg::work_t     q_data,
    output logic               q_pop,
    input  logic [31:0]        skin,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               overlap,
    output logic               hit,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [31:0]        penetration
);
    import cbm_pkg::*;

    logic               advance;
    logic               out_valid_reg;
    logic               overlap_reg;
    logic               hit_reg;
    logic signed [15:0] normal_x_reg;
    logic signed [15:0] normal_y_reg;
    logic [31:0]        penetration_reg;

    // The whole pipeline moves whenever the output register can take a word.
    assign advance = !out_valid_reg || !out_stall;
    assign q_pop   = advance && !q_empty;

    // ------------------------------------------------------------------
    // Stage B0: word taken from the queue.
    // ------------------------------------------------------------------
    logic  b0_valid_reg;
    work_t b0_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b0_valid_reg <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b0_word_reg <= q_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage B1: magnitudes and the per-axis reach test.
    // ------------------------------------------------------------------
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    item_t       b1_next;
    logic        b1_valid_reg;
    item_t       b1_item_reg;

    assign mag_x = b0_word_reg.vx[32] ? unsigned'(-b0_word_reg.vx) : unsigned'(b0_word_reg.vx);
    assign mag_y = b0_word_reg.vy[32] ? unsigned'(-b0_word_reg.vy) : unsigned'(b0_word_reg.vy);

    always_comb
    begin
        b1_next          = '0;
        b1_next.use_dist = b0_word_reg.use_dist;
        b1_next.flip     = b0_word_reg.flip;
        b1_next.fail     = (mag_x > {1'b0, b0_word_reg.rad}) ||
                           (mag_y > {1'b0, b0_word_reg.rad});
        b1_next.neg_x    = b0_word_reg.vx[32];
        b1_next.neg_y    = b0_word_reg.vy[32];
        b1_next.rad      = b0_word_reg.rad;
        b1_next.ax       = mag_x[31:0];
        b1_next.ay       = mag_y[31:0];
        b1_next.direct   = b0_word_reg.direct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b1_valid_reg <= b0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b1_item_reg <= b1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B2: squares of both offsets and of the radius.
    // ------------------------------------------------------------------
    logic        b2_valid_reg;
    item_t       b2_item_reg;
    logic [63:0] b2_sx_reg;
    logic [63:0] b2_sy_reg;
    logic [63:0] b2_rr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b2_item_reg <= b1_item_reg;
            b2_sx_reg   <= b1_item_reg.ax * b1_item_reg.ax;
            b2_sy_reg   <= b1_item_reg.ay * b1_item_reg.ay;
            b2_rr_reg   <= b1_item_reg.rad * b1_item_reg.rad;
        end
    end

    // ------------------------------------------------------------------
    // Stage B3: squared distance and the radius test.
    // ------------------------------------------------------------------
    logic [64:0] sum_sq;
    item_t       b3_next;
    logic        b3_valid_reg;
    item_t       b3_item_reg;
    logic [63:0] b3_sum_reg;

    assign sum_sq = {1'b0, b2_sx_reg} + {1'b0, b2_sy_reg};

    always_comb
    begin
        b3_next      = b2_item_reg;
        b3_next.fail = b2_item_reg.fail || sum_sq[64] || (sum_sq[63:0] > b2_rr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b3_item_reg <= b3_next;
            b3_sum_reg  <= sum_sq[63:0];
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, bit weight falling by four.
    // ------------------------------------------------------------------
    logic        sq_valid_reg [SQRT_STEPS];
    logic [63:0] sq_rem_reg   [SQRT_STEPS];
    logic [63:0] sq_res_reg   [SQRT_STEPS];
    item_t       sq_item_reg  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam int          Shift  = 62 - 2 * k;
        localparam logic [63:0] BitVal = 64'd1 << Shift;

        logic        v_in;
        logic [63:0] rem_in;
        logic [63:0] res_in;
        item_t       item_in;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        if (k == 0)
        begin : g_first
            assign v_in    = b3_valid_reg;
            assign rem_in  = b3_sum_reg;
            assign res_in  = '0;
            assign item_in = b3_item_reg;
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign res_in  = sq_res_reg[k-1];
            assign item_in = sq_item_reg[k-1];
        end

        assign trial = res_in + BitVal;

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BitVal;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (advance)
            begin
                sq_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sq_rem_reg[k]  <= rem_next;
                sq_res_reg[k]  <= res_next;
                sq_item_reg[k] <= item_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Normal divider: |offset| * 16384 / distance, one quotient bit per
    // stage for both axes side by side.
    // ------------------------------------------------------------------
    logic        dv_valid_reg [DIV_STEPS];
    logic [31:0] dv_remx_reg  [DIV_STEPS];
    logic [31:0] dv_remy_reg  [DIV_STEPS];
    logic [14:0] dv_qx_reg    [DIV_STEPS];
    logic [14:0] dv_qy_reg    [DIV_STEPS];
    logic [31:0] dv_d_reg     [DIV_STEPS];
    item_t       dv_item_reg  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic        v_in;
        logic [31:0] remx_in;
        logic [31:0] remy_in;
        logic        bitx_in;
        logic        bity_in;
        logic [14:0] qx_in;
        logic [14:0] qy_in;
        logic [31:0] d_in;
        item_t       item_in;
        logic [32:0] tx;
        logic [32:0] ty;
        logic [32:0] dx;
        logic [32:0] dy;
        logic        gex;
        logic        gey;

        if (j == 0)
        begin : g_first
            // The dividend is the magnitude shifted up by fourteen; its top
            // part already sits below the divisor.
            assign v_in    = sq_valid_reg[SQRT_STEPS-1];
            assign item_in = sq_item_reg[SQRT_STEPS-1];
            assign d_in    = sq_res_reg[SQRT_STEPS-1][31:0];
            assign remx_in = {1'b0, item_in.ax[31:1]};
            assign remy_in = {1'b0, item_in.ay[31:1]};
            assign bitx_in = item_in.ax[0];
            assign bity_in = item_in.ay[0];
            assign qx_in   = '0;
            assign qy_in   = '0;
        end
        else
        begin : g_rest
            assign v_in    = dv_valid_reg[j-1];
            assign item_in = dv_item_reg[j-1];
            assign d_in    = dv_d_reg[j-1];
            assign remx_in = dv_remx_reg[j-1];
            assign remy_in = dv_remy_reg[j-1];
            assign bitx_in = 1'b0;
            assign bity_in = 1'b0;
            assign qx_in   = dv_qx_reg[j-1];
            assign qy_in   = dv_qy_reg[j-1];
        end

        assign tx  = {remx_in, bitx_in};
        assign ty  = {remy_in, bity_in};
        assign gex = (tx >= {1'b0, d_in});
        assign gey = (ty >= {1'b0, d_in});
        assign dx  = gex ? tx - {1'b0, d_in} : tx;
        assign dy  = gey ? ty - {1'b0, d_in} : ty;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (advance)
            begin
                dv_valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_remx_reg[j] <= dx[31:0];
                dv_remy_reg[j] <= dy[31:0];
                dv_qx_reg[j]   <= {qx_in[13:0], gex};
                dv_qy_reg[j]   <= {qy_in[13:0], gey};
                dv_d_reg[j]    <= d_in;
                dv_item_reg[j] <= item_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result selection, saturation and the hit test.
    // ------------------------------------------------------------------
    item_t              fin_item;
    logic [31:0]        fin_d;
    logic signed [15:0] qx_s;
    logic signed [15:0] qy_s;
    logic signed [15:0] nx_d;
    logic signed [15:0] ny_d;
    contact_t           fin;
    logic [31:0]        pen_sat;

    assign fin_item = dv_item_reg[DIV_STEPS-1];
    assign fin_d    = dv_d_reg[DIV_STEPS-1];
    assign qx_s     = signed'({1'b0, dv_qx_reg[DIV_STEPS-1]});
    assign qy_s     = signed'({1'b0, dv_qy_reg[DIV_STEPS-1]});
    assign nx_d     = fin_item.neg_x ? -qx_s : qx_s;
    assign ny_d     = fin_item.neg_y ? -qy_s : qy_s;

    always_comb
    begin
        fin = fin_item.direct;
        if (fin_item.use_dist)
        begin
            fin = '0;
            if (!fin_item.fail)
            begin
                fin.ov = 1'b1;
                if (fin_d == '0)
                begin
                    // Coincident centres: fixed normal, half the radius sum.
                    fin.pen = {2'b00, fin_item.rad[31:1]};
                    fin.nx  = UNIT_NORMAL;
                end
                else
                begin
                    fin.pen = {1'b0, fin_item.rad} - {1'b0, fin_d};
                    fin.nx  = fin_item.flip ? -nx_d : nx_d;
                    fin.ny  = fin_item.flip ? -ny_d : ny_d;
                end
            end
        end
    end

    assign pen_sat = fin.pen[32] ? 32'hFFFF_FFFF : fin.pen[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            overlap_reg     <= fin.ov;
            hit_reg         <= fin.ov && (pen_sat > skin);
            normal_x_reg    <= fin.nx;
            normal_y_reg    <= fin.ny;
            penetration_reg <= pen_sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign overlap     = overlap_reg;
    assign hit         = hit_reg;
    assign normal_x    = normal_x_reg;
    assign normal_y    = normal_y_reg;
    assign penetration = penetration_reg;

endmodule

`default_nettype wire

@@ hdl/circle_box_collision_manifold.sv @@
// ----------------------------------------------------------------------------
// Circle and box collision manifold
// One shape pair per cycle sustained while no stall holds; the 32-stage root and 15-stage divider.
// Reset clears all valid bits, empties the queue and loads skin with 9830.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module circle_box_collision_manifold #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic [30:0]        first_size_a,
    input  logic [30:0]        first_size_b,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    input  logic [30:0]        second_size_a,
    input  logic [30:0]        second_size_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               overlap,
    output logic               hit,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic [31:0]        penetration
);
    import cbm_pkg::*;

    logic [31:0] skin_val_reg;
    logic        front_adv;
    logic        f_valid;
    work_t       f_word;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    work_t       q_data;

    // Hit threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skin_val_reg <= SKIN_RESET;
        end
        else if (cfg_we)
        begin
            skin_val_reg <= cfg_wdata;
        end
    end

    // The front moves unless its last word is waiting on a full queue.
    assign front_adv = !f_valid || !q_full;
    assign q_push    = f_valid && !q_full;
    assign in_stall  = !front_adv;

    cbm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (front_adv),
        .in_valid      (in_valid),
        .kind          (kind),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_size_a  (first_size_a),
        .first_size_b  (first_size_b),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_size_a (second_size_a),
        .second_size_b (second_size_b),
        .word_valid    (f_valid),
        .word          (f_word)
    );

    cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (f_word),
        .pop   (q_pop),
        .rdata (q_data),
        .full  (q_full),
        .empty (q_empty)
    );

    cbm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .skin        (skin_val_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .overlap     (overlap),
        .hit         (hit),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .penetration (penetration)
    );

    // Queue flow control and result consistency.
    `CBM_NEVER(a_queue_overflow, clk, rst_n, q_push && q_full, "word pushed into a full queue")
    `CBM_NEVER(a_queue_underflow, clk, rst_n, q_pop && q_empty, "word popped from an empty queue")
    `CBM_ASSERT(a_hit_needs_overlap, clk, rst_n, (out_valid && hit) |-> overlap, "hit without overlap")
    `CBM_ASSERT(a_miss_is_clear, clk, rst_n,
        (out_valid && !overlap) |-> ({penetration, normal_x, normal_y} == '0), "miss with nonzero contact")

endmodule

`default_nettype wire
